>>> hdl/lfsa_pkg.sv
// Shared beat types and field widths for the lowest free slot allocator.
package lfsa_pkg;

	localparam int FIELD_TIME_BITS = 32;
	localparam int SLOT_FIELD_BITS = 6;
	localparam int CFG_BITS        = 32;

	typedef struct packed {
		logic [FIELD_TIME_BITS-1:0] arrival_time;
		logic [FIELD_TIME_BITS-1:0] departure_time;
	} in_t;

	typedef struct packed {
		logic [SLOT_FIELD_BITS-1:0] slot_index;
		logic                       all_busy;
		logic                       is_target;
	} out_t;

endpackage

>>> hdl/lfsa_slot_ram.sv
// Busy-until store: one write port, one registered read port.
module lfsa_slot_ram #(
	parameter int DEPTH     = 64,
	parameter int WIDTH     = 32,
	parameter int ADDR_BITS = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/lowest_free_slot_allocator.sv
// Lowest free slot allocator: scans busy-until RAM for the first slot free at arrival.
// The scan is shortest when the slot at the high-water mark is taken and longest when
// every written slot is read; one RAM read per cycle sets the scan length.
// Throughput: one request in flight; the next beat is taken the cycle after the result is registered.
// Reset clears control, target and high-water mark; the RAM is not swept, entries at or
// above the high-water mark have never been written and count as free.
module lowest_free_slot_allocator #(
	parameter int SLOTS     = 64,
	parameter int TIME_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  lfsa_pkg::in_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output lfsa_pkg::out_t                out_data,
	input  logic                          cfg_we,
	input  logic [lfsa_pkg::CFG_BITS-1:0] cfg_wdata
);
	import lfsa_pkg::*;

	localparam int AW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                state_q;
	logic [CFG_BITS-1:0]   target_q;
	logic [TIME_BITS-1:0]  arr_q;
	logic [TIME_BITS-1:0]  dep_q;
	logic [CW-1:0]         idx_q;
	logic [CW-1:0]         hwm_q;
	logic                  cmp_v_s1;
	logic [AW-1:0]         idx_s1;
	logic [TIME_BITS-1:0]  rd_data_s1;
	out_t                  res_q;
	out_t                  out_q;
	logic                  out_valid_q;

	logic [TIME_BITS-1:0]  in_arr;
	logic [TIME_BITS-1:0]  in_dep;
	logic [TIME_BITS-1:0]  tgt_fit;
	logic                  accept;
	logic                  scan;
	logic                  hit;
	logic                  at_hwm;
	logic                  hwm_full;
	logic                  rd_en;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic                  load_out;

	assign in_arr   = TIME_BITS'(in_data.arrival_time);
	assign in_dep   = TIME_BITS'(in_data.departure_time);
	assign tgt_fit  = TIME_BITS'(target_q);
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign scan     = (state_q == ST_SCAN);
	assign hit      = cmp_v_s1 && (rd_data_s1 <= arr_q);
	assign at_hwm   = (idx_q == hwm_q);
	assign hwm_full = (hwm_q == CW'(SLOTS));
	assign rd_en    = scan && !hit && !at_hwm;
	assign wr_en    = scan && (hit || (at_hwm && !hwm_full));
	assign wr_addr  = hit ? idx_s1 : hwm_q[AW-1:0];
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	lfsa_slot_ram #(
		.DEPTH (SLOTS),
		.WIDTH (TIME_BITS)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (dep_q),
		.re    (rd_en),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_data_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			target_q    <= '0;
			hwm_q       <= '0;
			cmp_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				target_q <= cfg_wdata;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmp_v_s1 <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						cmp_v_s1 <= 1'b0;
						state_q  <= ST_DONE;
					end else if (at_hwm) begin
						cmp_v_s1 <= 1'b0;
						if (!hwm_full) begin
							hwm_q <= hwm_q + CW'(1);
						end
						state_q <= ST_DONE;
					end else begin
						cmp_v_s1 <= 1'b1;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			arr_q           <= in_arr;
			dep_q           <= in_dep;
			idx_q           <= '0;
			res_q.is_target <= (in_arr == tgt_fit);
		end
		if (rd_en) begin
			idx_s1 <= idx_q[AW-1:0];
			idx_q  <= idx_q + CW'(1);
		end
		if (scan && hit) begin
			res_q.slot_index <= SLOT_FIELD_BITS'(idx_s1);
			res_q.all_busy   <= 1'b0;
		end else if (scan && at_hwm) begin
			res_q.slot_index <= hwm_full ? '0 : SLOT_FIELD_BITS'(hwm_q);
			res_q.all_busy   <= hwm_full;
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> hdl/lfsa_checker.sv
// Port-level checks for the lowest free slot allocator, bound to the top level.
module lfsa_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input lfsa_pkg::out_t out_data
);
	import lfsa_pkg::*;

	logic [1:0] pending_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_beat && !out_beat) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_beat && !in_beat) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !in_ready)
		else $error("request beat taken while scan busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_busy_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_data.all_busy || out_data.slot_index == '0))
		else $error("dropped request carries nonzero slot");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pending_q != 2'd0 && pending_q != 2'd3))
		else $error("result without matching request");

endmodule

bind lowest_free_slot_allocator lfsa_checker u_lfsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

>>> verif/tb_lowest_free_slot_allocator.sv
// Self-checking testbench for the lowest free slot allocator, with a slot-table predictor.
`timescale 1ns / 1ps

module tb_lowest_free_slot_allocator;
	import lfsa_pkg::*;

	localparam int SLOT_COUNT  = 64;
	localparam int CYCLE_LIMIT = 500000;
	localparam int QUIET_FROM  = 6000;
	localparam int QUIET_TO    = 12000;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	in_t                 in_data   = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	out_t                out_data;
	logic                cfg_we    = 1'b0;
	logic [CFG_BITS-1:0] cfg_wdata = '0;

	in_t                        pending_reqs[$];
	out_t                       expected_grants[$];
	logic [FIELD_TIME_BITS-1:0] slot_busy[SLOT_COUNT];
	logic [FIELD_TIME_BITS-1:0] target_model;
	logic                       in_fire      = 1'b0;
	int                         cycle_cnt    = 0;
	int                         results_seen = 0;
	int                         items_queued = 0;
	int                         mismatch_cnt = 0;
	logic [FIELD_TIME_BITS-1:0] base;

	wire quiet_span = (cycle_cnt >= QUIET_FROM) && (cycle_cnt < QUIET_TO);

	lowest_free_slot_allocator #(
		.SLOTS(SLOT_COUNT),
		.TIME_BITS(FIELD_TIME_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// first slot whose busy-until time is at or before the arrival takes the beat
	function automatic out_t allocate_slot(in_t req);
		out_t grant;
		bit   found;
		grant = '0;
		found = 1'b0;
		for (int s = 0; s < SLOT_COUNT; s++) begin
			if (!found && slot_busy[s] <= req.arrival_time) begin
				slot_busy[s]     = req.departure_time;
				grant.slot_index = SLOT_FIELD_BITS'(s);
				found            = 1'b1;
			end
		end
		grant.all_busy  = !found;
		grant.is_target = (req.arrival_time == target_model);
		return grant;
	endfunction

	task automatic flag_mismatch(input string what);
		if (mismatch_cnt < 10)
			$display("%0d: %s", cycle_cnt, what);
		mismatch_cnt++;
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_fire) begin
				if (pending_reqs.size() > 0 && (quiet_span || $urandom_range(99) >= 10)) begin
					in_valid <= 1'b1;
					in_data  <= pending_reqs.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= quiet_span || ($urandom_range(99) >= 10);
		end
	end

	always @(posedge clk) begin : monitor_proc
		out_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++)
				slot_busy[i] = '0;
			target_model = '0;
			in_fire <= 1'b0;
		end else begin
			cycle_cnt <= cycle_cnt + 1;
			in_fire   <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (expected_grants.size() == 0) begin
					flag_mismatch($sformatf("unexpected beat: slot %0d busy %0b target %0b",
						out_data.slot_index, out_data.all_busy, out_data.is_target));
				end else begin
					want = expected_grants.pop_front();
					if (out_data.slot_index !== want.slot_index ||
						out_data.all_busy !== want.all_busy ||
						out_data.is_target !== want.is_target)
						flag_mismatch($sformatf(
							"expected slot %0d busy %0b target %0b, got slot %0d busy %0b target %0b",
							want.slot_index, want.all_busy, want.is_target,
							out_data.slot_index, out_data.all_busy, out_data.is_target));
				end
			end
			if (in_valid && in_ready)
				expected_grants.push_back(allocate_slot(in_data));
			if (cfg_we)
				target_model = cfg_wdata;
			if (cycle_cnt >= CYCLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic queue_req(input logic [FIELD_TIME_BITS-1:0] arr,
		input logic [FIELD_TIME_BITS-1:0] dep);
		pending_reqs.push_back(in_t'{arrival_time: arr, departure_time: dep});
		items_queued++;
	endtask

	task automatic wait_drained();
		while (results_seen != items_queued)
			@(negedge clk);
	endtask

	task automatic write_target(input logic [CFG_BITS-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// sorted arrivals with random holds, plus a few out-of-order and early-departure beats
	task automatic run_traffic(input int count, input logic [FIELD_TIME_BITS-1:0] start,
		input int step_max, input int dur_lo, input int dur_hi,
		output logic [FIELD_TIME_BITS-1:0] next_start);
		logic [FIELD_TIME_BITS-1:0] now;
		logic [FIELD_TIME_BITS-1:0] back;
		int                         pick;
		now = start;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 4) begin
				back = $urandom_range(0, 1000);
				if (back > now)
					back = now;
				queue_req($urandom, now - back);
			end else if (pick < 8) begin
				back = $urandom_range(1, 50);
				if (back > now)
					back = now;
				queue_req(now, now - back);
			end else begin
				now = now + $urandom_range(0, step_max);
				queue_req(now, now + $urandom_range(dur_lo, dur_hi));
			end
		end
		next_start = now + dur_hi + 1;
		wait_drained();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		write_target('0);

		queue_req(32'd0, 32'd0);
		queue_req(32'd0, 32'd5);
		queue_req(32'd0, 32'd5);
		queue_req(32'd2, 32'd1);
		queue_req(32'd2, 32'd9);
		queue_req(32'd5, 32'd7);
		queue_req(32'd1, 32'd3);
		queue_req(32'hFFFF_FFFF, 32'd2);
		queue_req(32'h5555_5555, 32'd10);
		queue_req(32'hAAAA_AAAA, 32'd10);
		queue_req(32'd8, 32'd8);
		queue_req(32'd8, 32'd20);
		wait_drained();

		// every slot taken at one arrival, then the overflow is dropped
		base = 32'd100;
		write_target(base);
		run_traffic(70, base, 0, 3000, 6000, base);

		write_target(base + 37);
		run_traffic(200, base, 4, 1, 30, base);

		write_target(base + 150);
		run_traffic(250, base, 2, 40, 160, base);

		base = 32'h7FFF_FF00 + $urandom_range(0, 255);
		write_target($urandom);
		run_traffic(150, base, 3, 20, 100, base);

		base = 32'hFFFF_FFFF - 700;
		write_target(32'hFFFF_FFFF);
		run_traffic(150, base, 8, 10, 120, base);

		queue_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_req(32'd0, 32'd0);
		queue_req(32'hFFFF_FFFF, 32'd0);
		queue_req(32'h8000_0000, 32'd1);
		wait_drained();

		repeat (SLOT_COUNT + 8) @(negedge clk);
		if (mismatch_cnt == 0 && expected_grants.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
